### hdl/assert_macros.svh
// assertion macros used by the checker file
// no dependencies; the including scope must provide clock and reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define LEMB_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// expression must never be true outside reset
`define LEMB_NEVER(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(expr)) else $error(msg);

`endif

### hdl/lemb_pkg.sv
// shared types and constants for the little-endian message buffer
// no dependencies; used by every module of the block
package lemb_pkg;

   localparam int STORE_BYTES = 4096;
   localparam int ADDR_W      = $clog2(STORE_BYTES);
   localparam int CNT_W       = 13;
   localparam int LEN_W       = 3;
   localparam int LANE_W      = 2;

   localparam logic [CNT_W:0] STORE_LIMIT = (CNT_W + 1)'(STORE_BYTES);

   typedef enum logic [2:0] {
      ACT_CLEAR   = 3'd0,
      ACT_REWIND  = 3'd1,
      ACT_WRITE   = 3'd2,
      ACT_READ    = 3'd3,
      ACT_SAVE    = 3'd4,
      ACT_RESTORE = 3'd5
   } action_type;

   typedef enum logic [1:0] {
      STAT_OK       = 2'd0,
      STAT_REFUSED  = 2'd1,
      STAT_OVERFLOW = 2'd2,
      STAT_BAD_READ = 2'd3
   } status_type;

   localparam logic [1:0] SIZE_BYTE  = 2'd0;
   localparam logic [1:0] SIZE_SHORT = 2'd1;

   typedef enum logic [2:0] {
      SEQ_IDLE,
      SEQ_DECODE,
      SEQ_WRITE,
      SEQ_READ,
      SEQ_DONE
   } seq_state_type;

   typedef struct packed {
      logic [31:0]      read_value;
      status_type       status;
      logic [CNT_W-1:0] fill_level;
      logic [CNT_W-1:0] read_position;
      logic             bad_read;
      logic             overflowed;
   } result_type;

   function automatic logic [LEN_W-1:0] size_len(input logic [1:0] code);
      logic [LEN_W-1:0] len;
      case (code)
         SIZE_BYTE:  len = LEN_W'(1);
         SIZE_SHORT: len = LEN_W'(2);
         default:    len = LEN_W'(4);
      endcase
      return len;
   endfunction

endpackage

### hdl/lemb_byte_ram.sv
// byte-wide single-port store with registered read data
// depends on lemb_pkg for depth and address width
module lemb_byte_ram (
   input  logic                        clock,
   input  logic                        we,
   input  logic [lemb_pkg::ADDR_W-1:0] addr,
   input  logic [7:0]                  wdata,
   output logic [7:0]                  rdata
);

   logic [7:0] mem [lemb_pkg::STORE_BYTES];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata <= mem[addr];
   end

endmodule

### hdl/lemb_seq.sv
// sequencer: decodes one request and moves its bytes through the store
// depends on lemb_pkg and lemb_byte_ram
module lemb_seq (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_fire,
   input  logic [2:0]              req_action,
   input  logic [1:0]              req_size,
   input  logic [31:0]             req_wval,
   input  logic                    allow_overflow,
   input  logic                    out_free,
   output logic                    idle,
   output logic                    done,
   output lemb_pkg::result_type    result
);

   localparam int CW = lemb_pkg::CNT_W;

   lemb_pkg::seq_state_type state_ff, state_in;
   lemb_pkg::action_type    act_ff, act_in;
   lemb_pkg::status_type    status_ff, status_in;

   logic [lemb_pkg::LEN_W-1:0]  len_ff, len_in;
   logic [lemb_pkg::LEN_W-1:0]  k_ff, k_in;
   logic [lemb_pkg::LANE_W-1:0] cap_ff, cap_in;
   logic                        pend_ff, pend_in;
   logic [31:0]                 wval_ff, wval_in;
   logic [31:0]                 rval_ff, rval_in;
   logic [CW-1:0]               base_ff, base_in;
   logic [CW-1:0]               fill_ff, fill_in;
   logic [CW-1:0]               rd_ff, rd_in;
   logic [CW-1:0]               saved_ff, saved_in;
   logic                        saved_vld_ff, saved_vld_in;
   logic                        bad_ff, bad_in;
   logic                        ovf_ff, ovf_in;

   // shared address unit: base plus byte offset, and the bounds sums
   logic [CW:0]                 wr_end;
   logic [CW:0]                 rd_end;
   logic [CW-1:0]               byte_addr;
   logic                        last_write;
   logic                        last_capture;
   logic                        issue;

   logic                        ram_we;
   logic [7:0]                  ram_q;

   assign byte_addr    = base_ff + CW'(k_ff);
   assign wr_end       = {1'b0, fill_ff} + (CW + 1)'(len_ff);
   assign rd_end       = {1'b0, rd_ff} + (CW + 1)'(len_ff);
   assign last_write   = (k_ff == len_ff - lemb_pkg::LEN_W'(1));
   assign last_capture = pend_ff &&
                         (cap_ff == lemb_pkg::LANE_W'(len_ff - lemb_pkg::LEN_W'(1)));
   assign issue        = (k_ff != len_ff);

   lemb_byte_ram u_ram (
      .clock (clock),
      .we    (ram_we),
      .addr  (byte_addr[lemb_pkg::ADDR_W-1:0]),
      .wdata (wval_ff[7:0]),
      .rdata (ram_q)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lemb_pkg::SEQ_IDLE: begin
            if (req_fire) state_in = lemb_pkg::SEQ_DECODE;
         end
         lemb_pkg::SEQ_DECODE: begin
            state_in = lemb_pkg::SEQ_DONE;
            if (act_ff == lemb_pkg::ACT_WRITE) begin
               if ((wr_end <= lemb_pkg::STORE_LIMIT) || allow_overflow) begin
                  state_in = lemb_pkg::SEQ_WRITE;
               end
            end else if (act_ff == lemb_pkg::ACT_READ) begin
               if (rd_end <= {1'b0, fill_ff}) state_in = lemb_pkg::SEQ_READ;
            end
         end
         lemb_pkg::SEQ_WRITE: begin
            if (last_write) state_in = lemb_pkg::SEQ_DONE;
         end
         lemb_pkg::SEQ_READ: begin
            if (last_capture) state_in = lemb_pkg::SEQ_DONE;
         end
         lemb_pkg::SEQ_DONE: begin
            if (out_free) state_in = lemb_pkg::SEQ_IDLE;
         end
         default: state_in = lemb_pkg::SEQ_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      idle   = (state_ff == lemb_pkg::SEQ_IDLE);
      done   = (state_ff == lemb_pkg::SEQ_DONE) && out_free;
      ram_we = (state_ff == lemb_pkg::SEQ_WRITE);
      result = '{read_value:    rval_ff,
                 status:        status_ff,
                 fill_level:    fill_ff,
                 read_position: rd_ff,
                 bad_read:      bad_ff,
                 overflowed:    ovf_ff};
   end

   // datapath
   always_comb begin
      act_in       = act_ff;
      status_in    = status_ff;
      len_in       = len_ff;
      k_in         = k_ff;
      cap_in       = cap_ff;
      pend_in      = 1'b0;
      wval_in      = wval_ff;
      rval_in      = rval_ff;
      base_in      = base_ff;
      fill_in      = fill_ff;
      rd_in        = rd_ff;
      saved_in     = saved_ff;
      saved_vld_in = saved_vld_ff;
      bad_in       = bad_ff;
      ovf_in       = ovf_ff;
      case (state_ff)
         lemb_pkg::SEQ_IDLE: begin
            if (req_fire) begin
               act_in  = lemb_pkg::action_type'(req_action);
               len_in  = lemb_pkg::size_len(req_size);
               wval_in = req_wval;
            end
         end
         lemb_pkg::SEQ_DECODE: begin
            rval_in   = '0;
            status_in = lemb_pkg::STAT_OK;
            k_in      = '0;
            cap_in    = '0;
            case (act_ff)
               lemb_pkg::ACT_CLEAR: begin
                  fill_in = '0;
                  rd_in   = '0;
                  bad_in  = 1'b0;
                  ovf_in  = 1'b0;
               end
               lemb_pkg::ACT_REWIND: begin
                  rd_in  = '0;
                  bad_in = 1'b0;
               end
               lemb_pkg::ACT_WRITE: begin
                  base_in = fill_ff;
                  if (wr_end > lemb_pkg::STORE_LIMIT) begin
                     if (!allow_overflow) begin
                        status_in = lemb_pkg::STAT_REFUSED;
                     end else begin
                        // overflow: start over from an empty store
                        base_in   = '0;
                        fill_in   = '0;
                        rd_in     = '0;
                        bad_in    = 1'b0;
                        ovf_in    = 1'b1;
                        status_in = lemb_pkg::STAT_OVERFLOW;
                     end
                  end
               end
               lemb_pkg::ACT_READ: begin
                  base_in = rd_ff;
                  if (rd_end > {1'b0, fill_ff}) begin
                     bad_in    = 1'b1;
                     rval_in   = '1;
                     status_in = lemb_pkg::STAT_BAD_READ;
                  end
               end
               lemb_pkg::ACT_SAVE: begin
                  saved_in     = rd_ff;
                  saved_vld_in = 1'b1;
               end
               lemb_pkg::ACT_RESTORE: begin
                  if (saved_vld_ff) begin
                     rd_in        = saved_ff;
                     saved_vld_in = 1'b0;
                  end
               end
               default: ;
            endcase
         end
         lemb_pkg::SEQ_WRITE: begin
            k_in    = k_ff + lemb_pkg::LEN_W'(1);
            wval_in = wval_ff >> 8;
            if (last_write) fill_in = base_ff + CW'(len_ff);
         end
         lemb_pkg::SEQ_READ: begin
            if (issue) begin
               k_in    = k_ff + lemb_pkg::LEN_W'(1);
               pend_in = 1'b1;
            end
            if (pend_ff) begin
               rval_in[cap_ff*8 +: 8] = ram_q;
               cap_in = cap_ff + lemb_pkg::LANE_W'(1);
            end
            if (last_capture) begin
               rd_in = base_ff + CW'(len_ff);
               if (len_ff == lemb_pkg::LEN_W'(2)) rval_in[31:16] = {16{ram_q[7]}};
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lemb_pkg::SEQ_IDLE;
         fill_ff      <= '0;
         rd_ff        <= '0;
         saved_ff     <= '0;
         saved_vld_ff <= 1'b0;
         bad_ff       <= 1'b0;
         ovf_ff       <= 1'b0;
         pend_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         rd_ff        <= rd_in;
         saved_ff     <= saved_in;
         saved_vld_ff <= saved_vld_in;
         bad_ff       <= bad_in;
         ovf_ff       <= ovf_in;
         pend_ff      <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff    <= act_in;
      status_ff <= status_in;
      len_ff    <= len_in;
      k_ff      <= k_in;
      cap_ff    <= cap_in;
      wval_ff   <= wval_in;
      rval_ff   <= rval_in;
      base_ff   <= base_in;
   end

endmodule

### hdl/little_endian_message_buffer.sv
// top level of the little-endian message buffer: handshakes, configuration, result register
// depends on lemb_pkg and lemb_seq
//
// usage
// - req channel: one request per action (clear, rewind, write, read, save, restore);
//   req_tuser carries the action and access size, req_tdata the value to append
// - rsp channel: exactly one response per request, in request order
// - csr channel: one-bit allow_overflow value, always ready; write it only while idle
// - from request accept to response valid, a request passes the decode state, then
//   the write or read state for writes that go ahead and reads in bounds, then the
//   done state, where the result enters the output register once it is free
// - throughput is one request at a time; the byte-wide store port moves one byte a cycle
//   and req_tready is high only while the sequencer is idle, so a new request is taken
//   only once the previous one has left the done state
// - a finished response waits in the output register; the sequencer may already
//   take the next request, but holds its own result until the register is free
// - reset clears fill level, read position, saved position, flags and allow_overflow;
//   store contents are undefined until written
module little_endian_message_buffer (
   input  logic        clock,
   input  logic        reset,
   // request
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] write_value
   input  logic [4:0]  req_tuser,   // [2:0] action, [4:3] size_code
   // response
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // [31:0] read_value, [44:32] fill_level,
                                    // [57:45] read_position, [58] bad_read,
                                    // [59] overflowed, [63:60] zero
   output logic [1:0]  rsp_tuser,   // [1:0] status
   // configuration
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_data     // allow_overflow
);

   logic                 allow_ff, allow_in;
   logic                 rsp_vld_ff, rsp_vld_in;
   lemb_pkg::result_type rsp_ff, rsp_in;

   logic                 req_fire;
   logic                 out_free;
   logic                 seq_idle;
   logic                 seq_done;
   lemb_pkg::result_type seq_result;

   // output register is free when empty or being drained this cycle
   assign out_free   = !rsp_vld_ff || rsp_tready;
   assign req_tready = seq_idle;
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   lemb_seq u_seq (
      .clock          (clock),
      .reset          (reset),
      .req_fire       (req_fire),
      .req_action     (req_tuser[2:0]),
      .req_size       (req_tuser[4:3]),
      .req_wval       (req_tdata),
      .allow_overflow (allow_ff),
      .out_free       (out_free),
      .idle           (seq_idle),
      .done           (seq_done),
      .result         (seq_result)
   );

   always_comb begin
      allow_in   = (csr_valid && csr_ready) ? csr_data : allow_ff;
      rsp_vld_in = rsp_vld_ff;
      rsp_in     = rsp_ff;
      if (rsp_vld_ff && rsp_tready) rsp_vld_in = 1'b0;
      // sequencer only reports done when the register can take it
      if (seq_done) begin
         rsp_vld_in = 1'b1;
         rsp_in     = seq_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         allow_ff   <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         allow_ff   <= allow_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tuser  = rsp_ff.status;
   assign rsp_tdata  = {4'b0000, rsp_ff.overflowed, rsp_ff.bad_read,
                        rsp_ff.read_position, rsp_ff.fill_level, rsp_ff.read_value};

endmodule

### hdl/lemb_checker.sv
// port-level checks for the little-endian message buffer, bound to the top level
// depends on assert_macros.svh and lemb_pkg
`include "assert_macros.svh"

module lemb_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [63:0] rsp_tdata,
   input logic [1:0]  rsp_tuser
);

   logic        bad_rsp;
   logic        ovf_rsp;
   logic [31:0] rsp_value;
   logic [13:0] rsp_fill;
   logic [13:0] rsp_rdpos;

   assign bad_rsp   = rsp_tvalid && (rsp_tuser == lemb_pkg::STAT_BAD_READ);
   assign ovf_rsp   = rsp_tvalid && (rsp_tuser == lemb_pkg::STAT_OVERFLOW);
   assign rsp_value = rsp_tdata[31:0];
   assign rsp_fill  = {1'b0, rsp_tdata[44:32]};
   assign rsp_rdpos = {1'b0, rsp_tdata[57:45]};

   // a stalled response stays offered
   `LEMB_ASSERT(a_rsp_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid, "response dropped")

   // a failed read gives all ones and raises the sticky flag
   `LEMB_ASSERT(a_bad_read, bad_rsp |-> rsp_value == 32'hffff_ffff && rsp_tdata[58], "bad read")

   // a write after overflow clear shows the overflow mark
   `LEMB_ASSERT(a_ovf_mark, ovf_rsp |-> rsp_tdata[59], "overflow mark missing")

   // fill level and read position never pass the store size
   `LEMB_NEVER(a_fill_range, rsp_tvalid && rsp_fill > lemb_pkg::STORE_LIMIT, "fill out of range")
   `LEMB_NEVER(a_rdpos_range, rsp_tvalid && rsp_rdpos > lemb_pkg::STORE_LIMIT, "position out of range")

endmodule

bind little_endian_message_buffer lemb_checker u_lemb_checker (.*);

### test/tb_little_endian_message_buffer.sv
// self-checking testbench for little_endian_message_buffer: requests and configuration
// writes flow from one queue into a clocked driver, and a clocked monitor checks each response
// depends on lemb_pkg and the little_endian_message_buffer rtl
`timescale 1ns / 100ps

module tb_little_endian_message_buffer;

   // action codes the block must ignore, and the two wider size codes
   localparam logic [2:0] ACT_SPARE_LO = 3'd6;
   localparam logic [2:0] ACT_SPARE_HI = 3'd7;
   localparam logic [1:0] SIZE_WORD    = 2'd2;
   localparam logic [1:0] SIZE_WIDE    = 2'd3;

   // settle for longer than the longest request takes
   localparam int SETTLE_CYCLES = 12;
   localparam int TAIL_CYCLES   = 20;
   localparam int IDLE_LIMIT    = 2000;

   typedef enum logic [1:0] {
      EN_REQUEST,
      EN_SETTING,
      EN_PAUSE
   } entry_kind_type;

   typedef struct {
      entry_kind_type kind;
      logic [2:0]     action;
      logic [1:0]     size_code;
      logic [31:0]    value;
      logic           setting;
   } pending_entry_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;   // [31:0] write_value
   logic [4:0]  req_tuser  = '0;   // [2:0] action, [4:3] size_code
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;         // [31:0] read_value, [44:32] fill_level,
                                   // [57:45] read_position, [58] bad_read, [59] overflowed
   logic [1:0]  rsp_tuser;         // [1:0] status
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic        csr_data   = 1'b0; // allow_overflow

   little_endian_message_buffer dut (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tuser    (req_tuser),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tuser    (rsp_tuser),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_data     (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ---------------------------------------------------------------------------
   // message store mirror: the expected view of the block after every request
   // ---------------------------------------------------------------------------
   logic [7:0] msg_bytes [0:lemb_pkg::STORE_BYTES-1];
   int         fill_bytes = 0;
   int         read_at    = 0;
   int         saved_at   = 0;
   bit         saved_ok   = 1'b0;
   bit         bad_flag   = 1'b0;
   bit         ovf_flag   = 1'b0;
   bit         allow_ovf  = 1'b0;

   lemb_pkg::result_type expected_results [$];
   pending_entry_type    pending_items [$];
   pending_entry_type    in_flight;

   int mismatches  = 0;
   int gap_left    = 0;
   int settle_left = SETTLE_CYCLES;
   int stall_left  = 0;
   int sender_calm = 0;
   int recv_calm   = 0;
   int quiet_cycles = 0;

   // size code 3 counts as four bytes
   function automatic int byte_count(input logic [1:0] code);
      return (code == lemb_pkg::SIZE_BYTE) ? 1 : (code == lemb_pkg::SIZE_SHORT) ? 2 : 4;
   endfunction

   task automatic wipe_message();
      fill_bytes = 0;
      read_at    = 0;
      bad_flag   = 1'b0;
      ovf_flag   = 1'b0;
   endtask

   // apply one accepted request to the mirror and queue the response it must give
   task automatic apply_request(input pending_entry_type ent);
      lemb_pkg::result_type res;
      int                   len;
      logic [31:0]          rval;
      lemb_pkg::status_type st;
      len  = byte_count(ent.size_code);
      rval = '0;
      st   = lemb_pkg::STAT_OK;
      case (ent.action)
         lemb_pkg::ACT_CLEAR: begin
            wipe_message();
         end
         lemb_pkg::ACT_REWIND: begin
            read_at  = 0;
            bad_flag = 1'b0;
         end
         lemb_pkg::ACT_WRITE: begin
            if (fill_bytes + len > lemb_pkg::STORE_BYTES && !allow_ovf) begin
               st = lemb_pkg::STAT_REFUSED;
            end else begin
               // no room but reuse allowed: start over and keep the overflow mark
               if (fill_bytes + len > lemb_pkg::STORE_BYTES) begin
                  wipe_message();
                  ovf_flag = 1'b1;
                  st       = lemb_pkg::STAT_OVERFLOW;
               end
               for (int i = 0; i < len; i++)
                  msg_bytes[fill_bytes + i] = ent.value[8*i +: 8];
               fill_bytes += len;
            end
         end
         lemb_pkg::ACT_READ: begin
            if (read_at + len > fill_bytes) begin
               bad_flag = 1'b1;
               rval     = '1;
               st       = lemb_pkg::STAT_BAD_READ;
            end else begin
               for (int i = 0; i < len; i++)
                  rval[8*i +: 8] = msg_bytes[read_at + i];
               // shorts sign-extend, bytes stay zero-extended
               if (len == 2 && rval[15])
                  rval[31:16] = '1;
               read_at += len;
            end
         end
         lemb_pkg::ACT_SAVE: begin
            saved_at = read_at;
            saved_ok = 1'b1;
         end
         lemb_pkg::ACT_RESTORE: begin
            if (saved_ok) begin
               read_at  = saved_at;
               saved_ok = 1'b0;
            end
         end
         default: begin
         end
      endcase
      res.read_value    = rval;
      res.status        = st;
      res.fill_level    = lemb_pkg::CNT_W'(fill_bytes);
      res.read_position = lemb_pkg::CNT_W'(read_at);
      res.bad_read      = bad_flag;
      res.overflowed    = ovf_flag;
      expected_results.push_back(res);
   endtask

   // ---------------------------------------------------------------------------
   // idle pattern: mostly back to back or short gaps, a few long ones,
   // and now and then a calm stretch with no idling at all
   // ---------------------------------------------------------------------------
   function automatic int pick_idle(inout int calm);
      int r;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 3) begin
         calm = $urandom_range(20, 80);
         return 0;
      end
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 50);
   endfunction

   // ---------------------------------------------------------------------------
   // stimulus queue helpers
   // ---------------------------------------------------------------------------
   task automatic push_request(input logic [2:0] act, input logic [1:0] sz,
                               input logic [31:0] val);
      pending_entry_type e;
      e.kind      = EN_REQUEST;
      e.action    = act;
      e.size_code = sz;
      e.value     = val;
      e.setting   = 1'b0;
      pending_items.push_back(e);
   endtask

   task automatic push_setting(input logic v);
      pending_entry_type e;
      e.kind      = EN_SETTING;
      e.action    = lemb_pkg::ACT_CLEAR;
      e.size_code = lemb_pkg::SIZE_BYTE;
      e.value     = '0;
      e.setting   = v;
      pending_items.push_back(e);
   endtask

   // sender holds off until every response is back
   task automatic push_pause();
      pending_entry_type e;
      e.kind      = EN_PAUSE;
      e.action    = lemb_pkg::ACT_CLEAR;
      e.size_code = lemb_pkg::SIZE_BYTE;
      e.value     = '0;
      e.setting   = 1'b0;
      pending_items.push_back(e);
   endtask

   function automatic logic [31:0] pick_value();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return '0;
      if (r == 1) return '1;
      return $urandom;
   endfunction

   task automatic push_noise();
      push_request(3'($urandom_range(0, 7)), 2'($urandom_range(0, 3)), $urandom);
   endtask

   // one message: usually a fresh store, a run of appends, then read back from the start
   task automatic queue_message();
      int         count;
      logic [1:0] sizes [0:9];
      logic [1:0] sz;
      count = $urandom_range(1, 10);
      if ($urandom_range(0, 9) < 6)
         push_request(lemb_pkg::ACT_CLEAR, 2'($urandom_range(0, 3)), $urandom);
      for (int i = 0; i < count; i++) begin
         sizes[i] = 2'($urandom_range(0, 3));
         push_request(lemb_pkg::ACT_WRITE, sizes[i], pick_value());
      end
      if ($urandom_range(0, 9) < 2)
         push_noise();
      push_request(lemb_pkg::ACT_REWIND, 2'($urandom_range(0, 3)), $urandom);
      for (int i = 0; i < count; i++) begin
         if (i == count / 2 && $urandom_range(0, 3) == 0)
            push_request(lemb_pkg::ACT_SAVE, 2'($urandom_range(0, 3)), $urandom);
         // mostly the sizes that were written, sometimes a mismatched one
         sz = ($urandom_range(0, 9) < 8) ? sizes[i] : 2'($urandom_range(0, 3));
         push_request(lemb_pkg::ACT_READ, sz, $urandom);
      end
      if ($urandom_range(0, 3) == 0) begin
         push_request(lemb_pkg::ACT_RESTORE, 2'($urandom_range(0, 3)), $urandom);
         push_request(lemb_pkg::ACT_READ, 2'($urandom_range(0, 3)), $urandom);
      end
      if ($urandom_range(0, 3) == 0)
         push_request(lemb_pkg::ACT_READ, 2'($urandom_range(0, 3)), $urandom);
      if ($urandom_range(0, 4) == 0)
         push_noise();
   endtask

   // ---------------------------------------------------------------------------
   // driver: one request or one configuration write at a time, taken from the queue
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin : request_driver
      logic next_req;
      logic next_csr;
      if (reset) begin
         req_tvalid <= 1'b0;
         csr_valid  <= 1'b0;
      end else begin
         next_req = req_tvalid && !req_tready;
         next_csr = csr_valid && !csr_ready;
         if (req_tvalid && req_tready)
            apply_request(in_flight);
         if (csr_valid && csr_ready)
            allow_ovf = csr_data;
         if (!next_req && !next_csr) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_items.size() > 0) begin
               if (pending_items[0].kind == EN_REQUEST) begin
                  in_flight = pending_items.pop_front();
                  req_tdata <= in_flight.value;
                  req_tuser <= {in_flight.size_code, in_flight.action};
                  next_req  = 1'b1;
                  gap_left  = pick_idle(sender_calm);
               end else if (expected_results.size() != 0) begin
                  // configuration writes and pauses wait for an idle block
                  settle_left = SETTLE_CYCLES;
               end else if (settle_left > 0) begin
                  settle_left--;
               end else begin
                  if (pending_items[0].kind == EN_SETTING) begin
                     csr_data <= pending_items[0].setting;
                     next_csr = 1'b1;
                  end
                  pending_items.delete(0);
                  settle_left = SETTLE_CYCLES;
               end
            end
         end
         req_tvalid <= next_req;
         csr_valid  <= next_csr;
      end
   end

   // ---------------------------------------------------------------------------
   // monitor: every response against the oldest expectation, field by field
   // ---------------------------------------------------------------------------
   task automatic report_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin : response_monitor
      lemb_pkg::result_type want;
      lemb_pkg::result_type got;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.read_value    = rsp_tdata[31:0];
            got.fill_level    = rsp_tdata[44:32];
            got.read_position = rsp_tdata[57:45];
            got.bad_read      = rsp_tdata[58];
            got.overflowed    = rsp_tdata[59];
            got.status        = lemb_pkg::status_type'(rsp_tuser);
            if (expected_results.size() == 0) begin
               $error("response with no request outstanding");
               mismatches++;
            end else begin
               want = expected_results.pop_front();
               report_field("read_value", want.read_value, got.read_value);
               report_field("status", 32'(want.status), 32'(got.status));
               report_field("fill_level", 32'(want.fill_level), 32'(got.fill_level));
               report_field("read_position", 32'(want.read_position),
                            32'(got.read_position));
               report_field("bad_read", 32'(want.bad_read), 32'(got.bad_read));
               report_field("overflowed", 32'(want.overflowed), 32'(got.overflowed));
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            stall_left = pick_idle(recv_calm);
            rsp_tready <= (stall_left == 0);
         end
      end
   end

   // watchdog: a stretch with no handshake on any channel means a hang
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= IDLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------------
   // stimulus and end of run
   // ---------------------------------------------------------------------------
   initial begin : stimulus
      int         planned;
      logic [1:0] sz;

      push_setting(1'b0);

      // directed: empty store, nothing saved, each size and sign, save and restore
      push_request(lemb_pkg::ACT_READ, lemb_pkg::SIZE_BYTE, 32'h0);    // read of an empty store
      push_request(lemb_pkg::ACT_RESTORE, lemb_pkg::SIZE_BYTE, 32'h0); // nothing saved yet
      push_request(lemb_pkg::ACT_REWIND, SIZE_WIDE, 32'hFFFF_FFFF);   // clears the bad-read flag
      push_request(lemb_pkg::ACT_WRITE, lemb_pkg::SIZE_BYTE, 32'hFFFF_FF80);
      push_request(lemb_pkg::ACT_WRITE, lemb_pkg::SIZE_SHORT, 32'h0000_8001);
      push_request(lemb_pkg::ACT_WRITE, SIZE_WORD, 32'hFFFF_FFFF);
      push_request(lemb_pkg::ACT_WRITE, SIZE_WIDE, 32'h0000_0000);    // wide code means four bytes
      push_request(lemb_pkg::ACT_WRITE, lemb_pkg::SIZE_SHORT, 32'h1234_7FFF);
      push_request(lemb_pkg::ACT_READ, lemb_pkg::SIZE_BYTE, 32'h0);    // byte zero-extends
      push_request(lemb_pkg::ACT_SAVE, lemb_pkg::SIZE_BYTE, 32'h0);
      push_request(lemb_pkg::ACT_READ, lemb_pkg::SIZE_SHORT, 32'h0);   // negative short
      push_request(lemb_pkg::ACT_READ, SIZE_WORD, 32'h0);
      push_request(lemb_pkg::ACT_RESTORE, lemb_pkg::SIZE_BYTE, 32'h0);
      push_request(lemb_pkg::ACT_READ, lemb_pkg::SIZE_SHORT, 32'h0);
      push_request(lemb_pkg::ACT_SAVE, lemb_pkg::SIZE_BYTE, 32'h0);
      push_request(lemb_pkg::ACT_SAVE, lemb_pkg::SIZE_BYTE, 32'h0);    // overwrite saved position
      push_request(lemb_pkg::ACT_READ, SIZE_WIDE, 32'h0);
      push_request(lemb_pkg::ACT_READ, SIZE_WIDE, 32'h0);
      push_request(lemb_pkg::ACT_READ, lemb_pkg::SIZE_SHORT, 32'h0);   // positive short, up to the end
      push_request(lemb_pkg::ACT_READ, lemb_pkg::SIZE_BYTE, 32'h0);
      push_request(ACT_SPARE_LO, SIZE_WORD, 32'hFFFF_FFFF);
      push_request(ACT_SPARE_HI, SIZE_WIDE, 32'h0);
      push_request(lemb_pkg::ACT_CLEAR, lemb_pkg::SIZE_BYTE, 32'h0);   // keeps saved position
      push_request(lemb_pkg::ACT_RESTORE, lemb_pkg::SIZE_BYTE, 32'h0); // stale: beyond fill level
      push_request(lemb_pkg::ACT_READ, lemb_pkg::SIZE_BYTE, 32'h0);
      push_request(lemb_pkg::ACT_REWIND, lemb_pkg::SIZE_BYTE, 32'h0);

      // random messages with reuse off
      for (int n = 0; n < 18; n++) begin
         queue_message();
         if (n == 9)
            push_pause();
      end

      push_setting(1'b1);
      for (int n = 0; n < 14; n++)
         queue_message();

      // fill the store to the last byte with reuse off
      push_setting(1'b0);
      push_request(lemb_pkg::ACT_CLEAR, lemb_pkg::SIZE_BYTE, $urandom);
      planned = 0;
      while (planned < lemb_pkg::STORE_BYTES - 8) begin
         sz = ($urandom_range(0, 9) < 8) ? SIZE_WORD : 2'($urandom_range(0, 3));
         push_request(lemb_pkg::ACT_WRITE, sz, pick_value());
         planned += byte_count(sz);
         if ($urandom_range(0, 49) == 0)
            push_request(lemb_pkg::ACT_READ, 2'($urandom_range(0, 3)), $urandom);
      end
      while (planned < lemb_pkg::STORE_BYTES - 3) begin
         push_request(lemb_pkg::ACT_WRITE, lemb_pkg::SIZE_BYTE, pick_value());
         planned++;
      end
      push_request(lemb_pkg::ACT_WRITE, SIZE_WORD, $urandom);            // refused, three free
      push_request(lemb_pkg::ACT_WRITE, lemb_pkg::SIZE_SHORT, $urandom);
      push_request(lemb_pkg::ACT_WRITE, lemb_pkg::SIZE_SHORT, $urandom); // refused, one free
      push_request(lemb_pkg::ACT_WRITE, lemb_pkg::SIZE_BYTE, $urandom);  // store now full
      push_request(lemb_pkg::ACT_WRITE, lemb_pkg::SIZE_BYTE, $urandom);
      push_request(lemb_pkg::ACT_WRITE, SIZE_WIDE, $urandom);
      push_request(lemb_pkg::ACT_REWIND, lemb_pkg::SIZE_BYTE, 32'h0);
      push_request(lemb_pkg::ACT_READ, SIZE_WORD, 32'h0);
      push_request(lemb_pkg::ACT_SAVE, lemb_pkg::SIZE_BYTE, 32'h0);

      // reuse on: the next write starts the store over and sets the overflow mark
      push_setting(1'b1);
      push_request(lemb_pkg::ACT_WRITE, SIZE_WORD, pick_value());
      push_request(lemb_pkg::ACT_WRITE, lemb_pkg::SIZE_SHORT, pick_value());
      push_request(lemb_pkg::ACT_REWIND, lemb_pkg::SIZE_BYTE, 32'h0);
      push_request(lemb_pkg::ACT_READ, SIZE_WORD, 32'h0);
      push_request(lemb_pkg::ACT_RESTORE, lemb_pkg::SIZE_BYTE, 32'h0); // stale, from full store
      push_request(lemb_pkg::ACT_READ, lemb_pkg::SIZE_SHORT, 32'h0);
      for (int n = 0; n < 5; n++)
         queue_message();

      push_setting(1'b0);
      for (int n = 0; n < 10; n++)
         queue_message();
      push_setting(1'b1);

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // sample after the edge has settled so the last pop is seen
      while (pending_items.size() != 0 || req_tvalid || csr_valid ||
             expected_results.size() != 0)
         @(negedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (mismatches == 0 && expected_results.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

### files.f
+incdir+hdl
hdl/lemb_pkg.sv
hdl/lemb_byte_ram.sv
hdl/lemb_seq.sv
hdl/little_endian_message_buffer.sv
hdl/lemb_checker.sv
test/tb_little_endian_message_buffer.sv
